FILE: hdl/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

    // Table geometry.
    localparam int MAX_BLOCKS = 64;
    localparam int SIZE_BITS  = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // Port field widths.
    localparam int KIND_W   = 1;
    localparam int REQ_W    = 32;
    localparam int BLK_W    = 6;
    localparam int STATUS_W = 2;

    // Common widths for comparing sizes and block numbers.
    localparam int CMP_W     = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
    localparam int TGT_CMP_W = (BLK_W > CNT_W) ? BLK_W : CNT_W;

    // Largest size that a table entry can hold.
    localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'({SIZE_BITS{1'b1}});

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_UNUSED       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_FREE_RD,
        S_HOLD
    } t_state;

    // One block record of the table.
    typedef struct packed {
        logic                 free;
        logic [SIZE_BITS-1:0] size;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_tbl_rd;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           entry;
    } t_tbl_wr;

endpackage

FILE: hdl/ffba_table.sv
`timescale 1ns / 1ps

module ffba_table import ffba_pkg::*; (
    input  logic    i_clk,
    input  t_tbl_rd i_rd,
    output t_entry  o_rd_data,
    input  t_tbl_wr i_wr
);

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/first_fit_block_allocator.sv
`timescale 1ns / 1ps

// First-fit block allocator. Block records (a size and a free mark) live in a
// single-port-read table and are appended in order. An allocate walks the table
// from entry 0, one entry per cycle through the table's registered read port,
// and takes the first free block that is large enough; if none fits it appends
// a block of the requested size, or answers table full. A free marks the named
// block free after one table read. One request is in work at a time. An
// allocate that finds no fit reads every block in use before it appends or
// answers table full; a free whose block number is not in use is answered
// without a table read. A finished result waits in the output register while
// the next request is taken. The table is not cleared after reset; the block
// count r_count starts at zero.

module first_fit_block_allocator import ffba_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [REQ_W-1:0]    i_request_size,
    input  logic [BLK_W-1:0]    i_target_block,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [BLK_W-1:0]    o_granted_block,
    output logic                o_was_reused,
    output logic [REQ_W-1:0]    o_granted_size
);

    t_state             r_state, n_state;
    logic [CMP_W-1:0]   r_want, n_want;
    logic [BLK_W-1:0]   r_target, n_target;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;

    t_status            r_res_status, n_res_status;
    logic [BLK_W-1:0]   r_res_block, n_res_block;
    logic               r_res_reused, n_res_reused;
    logic [REQ_W-1:0]   r_res_size, n_res_size;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [BLK_W-1:0]   r_out_block;
    logic               r_out_reused;
    logic [REQ_W-1:0]   r_out_size;

    t_tbl_rd            tbl_rd;
    t_tbl_wr            tbl_wr;
    t_entry             rd_data;
    logic               out_load;

    ffba_table u_table (
        .i_clk     (i_clk),
        .i_rd      (tbl_rd),
        .o_rd_data (rd_data),
        .i_wr      (tbl_wr)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign out_load = (r_state == S_HOLD) && (!r_out_valid || !i_stall);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Request and result holding registers.
    always_ff @(posedge i_clk) begin
        r_want       <= n_want;
        r_target     <= n_target;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_res_reused <= n_res_reused;
        r_res_size   <= n_res_size;
    end

    // Sequencer: scan, append, free and result hand-off.
    always_comb begin
        n_state      = r_state;
        n_want       = r_want;
        n_target     = r_target;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        n_res_reused = r_res_reused;
        n_res_size   = r_res_size;
        tbl_rd       = '0;
        tbl_wr       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_want   = CMP_W'(i_request_size);
                    n_target = i_target_block;
                    if (i_kind == KIND_ALLOC) begin
                        if (r_count == '0) begin
                            n_state = S_APPEND;
                        end else begin
                            tbl_rd.en   = 1'b1;
                            tbl_rd.addr = '0;
                            n_idx       = '0;
                            n_state     = S_SCAN;
                        end
                    end else if (TGT_CMP_W'(i_target_block) >= TGT_CMP_W'(r_count)) begin
                        // The block number was never handed out.
                        n_res_status = ST_UNUSED;
                        n_res_block  = i_target_block;
                        n_res_reused = 1'b0;
                        n_res_size   = '0;
                        n_state      = S_HOLD;
                    end else begin
                        tbl_rd.en   = 1'b1;
                        tbl_rd.addr = IDX_W'(i_target_block);
                        n_state     = S_FREE_RD;
                    end
                end
            end

            S_SCAN: begin
                // Data of entry r_idx is on the read port this cycle.
                if (rd_data.free && (CMP_W'(rd_data.size) >= r_want)) begin
                    tbl_wr.en          = 1'b1;
                    tbl_wr.addr        = r_idx;
                    tbl_wr.entry.free  = 1'b0;
                    tbl_wr.entry.size  = rd_data.size;
                    n_res_status       = ST_OK;
                    n_res_block        = BLK_W'(TGT_CMP_W'(r_idx));
                    n_res_reused       = 1'b1;
                    n_res_size         = REQ_W'(CMP_W'(rd_data.size));
                    n_state            = S_HOLD;
                end else if ((CNT_W'(r_idx) + CNT_W'(1)) == r_count) begin
                    n_state = S_APPEND;
                end else begin
                    n_idx       = r_idx + IDX_W'(1);
                    tbl_rd.en   = 1'b1;
                    tbl_rd.addr = n_idx;
                end
            end

            S_APPEND: begin
                if ((r_count == CNT_W'(MAX_BLOCKS)) || (r_want > SIZE_MAX)) begin
                    n_res_status = ST_FULL;
                    n_res_block  = '0;
                    n_res_reused = 1'b0;
                    n_res_size   = '0;
                end else begin
                    tbl_wr.en         = 1'b1;
                    tbl_wr.addr       = r_count[IDX_W-1:0];
                    tbl_wr.entry.free = 1'b0;
                    tbl_wr.entry.size = SIZE_BITS'(r_want);
                    n_count           = r_count + CNT_W'(1);
                    n_res_status      = ST_OK;
                    n_res_block       = BLK_W'(TGT_CMP_W'(r_count));
                    n_res_reused      = 1'b0;
                    n_res_size        = REQ_W'(r_want);
                end
                n_state = S_HOLD;
            end

            S_FREE_RD: begin
                n_res_block  = r_target;
                n_res_reused = 1'b0;
                n_res_size   = REQ_W'(CMP_W'(rd_data.size));
                if (rd_data.free) begin
                    n_res_status = ST_ALREADY_FREE;
                end else begin
                    tbl_wr.en         = 1'b1;
                    tbl_wr.addr       = IDX_W'(r_target);
                    tbl_wr.entry.free = 1'b1;
                    tbl_wr.entry.size = rd_data.size;
                    n_res_status      = ST_OK;
                end
                n_state = S_HOLD;
            end

            S_HOLD: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_block  <= r_res_block;
            r_out_reused <= r_res_reused;
            r_out_size   <= r_res_size;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_block = r_out_block;
    assign o_was_reused    = r_out_reused;
    assign o_granted_size  = r_out_size;

endmodule

FILE: tb/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    // One expected answer of the allocator.
    typedef struct packed {
        t_status            status;
        logic [BLK_W-1:0]   blk;
        logic               reused;
        logic [REQ_W-1:0]   size;
    } t_grant;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [REQ_W-1:0]    i_request_size;
    logic [BLK_W-1:0]    i_target_block;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [BLK_W-1:0]    o_granted_block;
    logic                o_was_reused;
    logic [REQ_W-1:0]    o_granted_size;

    // Shadow copy of the block table.
    logic [SIZE_BITS-1:0] shadow_size [MAX_BLOCKS];
    logic                 shadow_free [MAX_BLOCKS];
    int                   shadow_count = 0;

    t_grant grants_due[$];
    int     error_count = 0;
    bit     no_idle = 1'b0;
    int     holdoff_asked = 0;

    first_fit_block_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_request_size  (i_request_size),
        .i_target_block  (i_target_block),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .o_was_reused    (o_was_reused),
        .o_granted_size  (o_granted_size)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Works out the answer to one request and updates the shadow table.
    function automatic t_grant grant_for_request(logic [KIND_W-1:0] kind,
                                                 logic [REQ_W-1:0] want,
                                                 logic [BLK_W-1:0] tgt);
        t_grant g;
        g.status = ST_OK;
        g.blk    = '0;
        g.reused = 1'b0;
        g.size   = '0;
        if (kind == KIND_ALLOC) begin
            // First free block that is large enough wins.
            for (int i = 0; i < shadow_count; i++) begin
                if (shadow_free[i] && shadow_size[i] >= want) begin
                    shadow_free[i] = 1'b0;
                    g.blk    = BLK_W'(i);
                    g.reused = 1'b1;
                    g.size   = shadow_size[i];
                    return g;
                end
            end
            if (shadow_count >= MAX_BLOCKS) begin
                g.status = ST_FULL;
                return g;
            end
            shadow_size[shadow_count] = want;
            shadow_free[shadow_count] = 1'b0;
            g.blk  = BLK_W'(shadow_count);
            g.size = want;
            shadow_count++;
        end else begin
            g.blk = tgt;
            if (tgt >= shadow_count) begin
                g.status = ST_UNUSED;
            end else if (shadow_free[tgt]) begin
                g.status = ST_ALREADY_FREE;
                g.size   = shadow_size[tgt];
            end else begin
                shadow_free[tgt] = 1'b1;
                g.size = shadow_size[tgt];
            end
        end
        return g;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Offers one request and waits for its transfer; called at a rising edge.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [REQ_W-1:0] want,
                                input logic [BLK_W-1:0] tgt);
        if (!no_idle && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_request_size <= want;
        i_target_block <= tgt;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        grants_due.push_back(grant_for_request(kind, want, tgt));
    endtask

    // Stops offering and waits until every answer has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        wait (grants_due.size() == 0);
        @(posedge i_clk);
    endtask

    // One random request, biased toward blocks that exist and sizes that matter.
    task automatic random_request();
        logic [KIND_W-1:0] kind;
        logic [REQ_W-1:0]  want;
        logic [BLK_W-1:0]  tgt;
        int                roll;
        want = $urandom;
        tgt  = BLK_W'($urandom_range(63));
        if ($urandom_range(99) < 50) begin
            kind = KIND_ALLOC;
            roll = $urandom_range(3);
            if (roll == 0) begin
                want = $urandom_range(255);
            end else if (roll == 1 && shadow_count > 0) begin
                // Just below, at or just above an existing block's size.
                want = shadow_size[$urandom_range(shadow_count - 1)]
                       + REQ_W'($urandom_range(2)) - 1;
            end else if (roll == 2) begin
                case ($urandom_range(3))
                    0: want = '0;
                    1: want = '1;
                    2: want = REQ_W'(1) << $urandom_range(REQ_W - 1);
                    default: want = ~(REQ_W'(1) << $urandom_range(REQ_W - 1));
                endcase
            end
        end else begin
            kind = KIND_FREE;
            if (shadow_count > 0 && $urandom_range(99) < 70) begin
                tgt = BLK_W'($urandom_range(shadow_count - 1));
            end
        end
        send_request(kind, want, tgt);
    endtask

    // Empty table, first appends, frees, double frees and reuse.
    task automatic test_fresh_table();
        send_request(KIND_FREE,  32'h0000_0000, 6'd0);
        send_request(KIND_FREE,  32'hFFFF_FFFF, 6'd63);
        send_request(KIND_ALLOC, 32'h0000_0000, 6'd63);
        send_request(KIND_ALLOC, 32'hFFFF_FFFF, 6'd0);
        send_request(KIND_ALLOC, 32'd100,       6'h2A);
        send_request(KIND_ALLOC, 32'hAAAA_AAAA, 6'h15);
        send_request(KIND_ALLOC, 32'h5555_5555, 6'd0);
        send_request(KIND_FREE,  32'd0,         6'd1);
        send_request(KIND_FREE,  32'd0,         6'd1);
        send_request(KIND_ALLOC, 32'd5,         6'd0);
        send_request(KIND_FREE,  32'd0,         6'd0);
        send_request(KIND_ALLOC, 32'd0,         6'd0);
        send_request(KIND_FREE,  32'd0,         6'd2);
        send_request(KIND_ALLOC, 32'd101,       6'd0);
        send_request(KIND_ALLOC, 32'd100,       6'd0);
        send_request(KIND_FREE,  32'd0,         6'd6);
        send_request(KIND_FREE,  32'd0,         6'd7);
        send_request(KIND_FREE,  32'd0,         6'd63);
        send_request(KIND_ALLOC, 32'd99,        6'd0);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) random_request();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_receiver_holdoff();
        holdoff_asked++;
        repeat (12) random_request();
    endtask

    task automatic test_pause_until_drained();
        drain_results();
        repeat (3) random_request();
    endtask

    // A long run with no idling on either side.
    task automatic test_gap_free_stream(input int count);
        no_idle = 1'b1;
        repeat (count) random_request();
        no_idle = 1'b0;
    endtask

    // Fill every entry, then ask for the largest size, free block 63 twice and allocate once more.
    task automatic test_table_full();
        while (shadow_count < MAX_BLOCKS) begin
            send_request(KIND_ALLOC, REQ_W'($urandom_range(1, 4096)),
                         BLK_W'($urandom_range(63)));
        end
        repeat (6) send_request(KIND_ALLOC, 32'hFFFF_FFFF, BLK_W'($urandom_range(63)));
        send_request(KIND_FREE, $urandom, 6'd63);
        send_request(KIND_FREE, $urandom, 6'd63);
        send_request(KIND_ALLOC, 32'd0, 6'd0);
    endtask

    // Receiver: random stalls, with a counted hold-off when one is asked for.
    initial begin
        int holdoff_served;
        int holdoff_left;
        holdoff_served = 0;
        holdoff_left   = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                i_stall <= 1'b1;
                holdoff_left--;
            end else if (holdoff_served < holdoff_asked) begin
                holdoff_served++;
                holdoff_left = 150;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !no_idle && ($urandom_range(99) < 10);
            end
        end
    end

    // Compare each result transfer with the oldest expected answer.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (grants_due.size() == 0) begin
                note_error($sformatf("result with none expected: st=%0d blk=%0d re=%0b sz=%h",
                                     o_status, o_granted_block, o_was_reused,
                                     o_granted_size));
            end else begin
                want = grants_due.pop_front();
                if (o_status !== want.status || o_granted_block !== want.blk ||
                    o_was_reused !== want.reused || o_granted_size !== want.size) begin
                    note_error($sformatf({"mismatch: exp st=%0d blk=%0d re=%0b sz=%h, ",
                                          "got st=%0d blk=%0d re=%0b sz=%h"},
                                         want.status, want.blk, want.reused, want.size,
                                         o_status, o_granted_block, o_was_reused,
                                         o_granted_size));
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KIND_ALLOC;
        i_request_size = '0;
        i_target_block = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fresh_table();
        test_random_mix(300);
        test_receiver_holdoff();
        test_pause_until_drained();
        test_gap_free_stream(100);
        test_table_full();
        test_random_mix(380);

        drain_results();
        repeat (MAX_BLOCKS + 8) @(posedge i_clk);
        if (error_count == 0 && grants_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
